/* sv/trbp_pkg.sv */
// ----------------------------------------------------------------------------
// trbp_pkg
// Types, field kinds and helpers shared by the track run box parser modules.
// ----------------------------------------------------------------------------
package trbp_pkg;

   typedef enum logic [2:0] {
      KIND_COUNT       = 3'd0,
      KIND_DATA_OFFSET = 3'd1,
      KIND_FIRST_FLAGS = 3'd2,
      KIND_DURATION    = 3'd3,
      KIND_SIZE        = 3'd4,
      KIND_FLAGS       = 3'd5,
      KIND_COMP_OFFSET = 3'd6,
      KIND_NONE        = 3'd7
   } kind_type;

   // Held flag bits: data offset, first-sample flags, then the four per-sample fields.
   localparam int FLAG_DATA_OFFSET = 0;
   localparam int FLAG_FIRST_FLAGS = 1;
   localparam int HELD_FLAGS_W     = 6;

   // Box flag bit positions
   localparam int BOX_FLAG_DATA_OFFSET = 0;
   localparam int BOX_FLAG_FIRST_FLAGS = 2;
   localparam int BOX_FLAG_SAMPLE_LO   = 8;

   typedef logic [HELD_FLAGS_W-1:0] held_flags_type;

   // One assembled word handed from the byte front end to the field sequencer
   typedef struct packed {
      logic [31:0]    word;
      logic           first;   // first word of a new box body
      held_flags_type flags;   // flags of that box, meaningful when first is set
   } word_entry_type;

   function automatic held_flags_type map_flags(input logic [23:0] box_flags);
      held_flags_type result;
      result = {box_flags[BOX_FLAG_SAMPLE_LO+3:BOX_FLAG_SAMPLE_LO],
                box_flags[BOX_FLAG_FIRST_FLAGS], box_flags[BOX_FLAG_DATA_OFFSET]};
      return result;
   endfunction

   // First per-sample kind at or after 'from' whose flag is held
   function automatic kind_type next_sample_kind(input held_flags_type flags,
                                                 input kind_type from);
      kind_type result;
      logic     found;
      result = KIND_NONE;
      found  = 1'b0;
      for (int k = int'(KIND_DURATION); k <= int'(KIND_COMP_OFFSET); k++) begin
         if (!found && (k >= int'(from)) && flags[k-1]) begin
            result = kind_type'(3'(k));
            found  = 1'b1;
         end
      end
      return result;
   endfunction

endpackage

/* sv/trbp_front.sv */
// ----------------------------------------------------------------------------
// trbp_front
// Byte front end: packs big-endian bytes into 32-bit words, marks box starts.
// ----------------------------------------------------------------------------
module trbp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_accept,
   input  logic [7:0]              data_byte,
   input  logic                    box_start,
   input  logic [23:0]             box_flags,
   output logic                    push,
   output trbp_pkg::word_entry_type push_entry
);
   import trbp_pkg::*;

   logic [1:0]     pos_ff, pos_in;
   logic [23:0]    acc_ff, acc_in;
   logic           first_ff, first_in;
   held_flags_type flags_ff, flags_in;

   logic [1:0]     pos_eff;
   logic [23:0]    acc_eff;
   logic           first_eff;

   always_comb begin
      pos_eff   = box_start ? 2'd0 : pos_ff;
      acc_eff   = box_start ? 24'd0 : acc_ff;
      first_eff = box_start | first_ff;

      pos_in   = pos_ff;
      acc_in   = acc_ff;
      first_in = first_ff;
      flags_in = flags_ff;
      push     = 1'b0;

      push_entry.word  = {acc_eff, data_byte};
      push_entry.first = first_eff;
      push_entry.flags = box_start ? map_flags(box_flags) : flags_ff;

      if (byte_accept) begin
         flags_in = push_entry.flags;
         if (pos_eff == 2'd3) begin
            push     = 1'b1;
            pos_in   = 2'd0;
            acc_in   = 24'd0;
            first_in = 1'b0;
         end else begin
            pos_in   = pos_eff + 2'd1;
            acc_in   = {acc_eff[15:0], data_byte};
            first_in = first_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         first_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         first_ff <= first_in;
      end
      acc_ff   <= acc_in;
      flags_ff <= flags_in;
   end

endmodule

/* sv/trbp_fifo.sv */
// ----------------------------------------------------------------------------
// trbp_fifo
// Two-entry word queue between the byte front end and the field sequencer.
// ----------------------------------------------------------------------------
module trbp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  trbp_pkg::word_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     not_empty,
   output trbp_pkg::word_entry_type pop_entry
);
   import trbp_pkg::*;

   word_entry_type mem_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* sv/trbp_back.sv */
// ----------------------------------------------------------------------------
// trbp_back
// Field sequencer: walks the header and per-sample fields word by word and
// registers one result per word of an active run.
// ----------------------------------------------------------------------------
module trbp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_not_empty,
   input  trbp_pkg::word_entry_type q_entry,
   output logic                     q_pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output trbp_pkg::kind_type       out_kind,
   output logic [31:0]              out_value,
   output logic [31:0]              out_index,
   output logic                     out_last
);
   import trbp_pkg::*;

   kind_type       field_ff, field_in;
   held_flags_type flags_ff, flags_in;
   logic [31:0]    remain_ff, remain_in;
   logic [31:0]    counter_ff, counter_in;
   logic           done_ff, done_in;

   logic           ov_ff, ov_in;
   kind_type       ok_ff, ok_in;
   logic [31:0]    oval_ff, oval_in;
   logic [31:0]    oidx_ff, oidx_in;
   logic           olast_ff, olast_in;

   held_flags_type eff_flags;
   kind_type       eff_kind, next_kind, after;
   logic [31:0]    eff_remain, eff_counter, new_remain, new_counter;
   logic           eff_done, load;
   logic           q_first;

   always_comb begin
      // an empty queue presents a stale entry; only a held word may restart
      q_first     = q_not_empty && q_entry.first;
      eff_flags   = q_first ? q_entry.flags : flags_ff;
      eff_kind    = q_first ? KIND_COUNT : field_ff;
      eff_remain  = q_first ? 32'd0 : remain_ff;
      eff_counter = q_first ? 32'd0 : counter_ff;
      eff_done    = q_first ? 1'b0 : done_ff;

      new_remain  = eff_remain;
      new_counter = eff_counter;
      after       = KIND_NONE;

      unique case (eff_kind)
         KIND_COUNT: begin
            new_remain = q_entry.word;
            if (eff_flags[FLAG_DATA_OFFSET]) begin
               next_kind = KIND_DATA_OFFSET;
            end else if (eff_flags[FLAG_FIRST_FLAGS]) begin
               next_kind = KIND_FIRST_FLAGS;
            end else begin
               next_kind = (q_entry.word == 32'd0) ? KIND_NONE
                         : next_sample_kind(eff_flags, KIND_DURATION);
            end
         end
         KIND_DATA_OFFSET: begin
            if (eff_flags[FLAG_FIRST_FLAGS]) begin
               next_kind = KIND_FIRST_FLAGS;
            end else begin
               next_kind = (eff_remain == 32'd0) ? KIND_NONE
                         : next_sample_kind(eff_flags, KIND_DURATION);
            end
         end
         KIND_FIRST_FLAGS: begin
            next_kind = (eff_remain == 32'd0) ? KIND_NONE
                      : next_sample_kind(eff_flags, KIND_DURATION);
         end
         KIND_NONE: begin
            // never held while a run is active
            next_kind = KIND_NONE;
         end
         default: begin
            after = next_sample_kind(eff_flags, kind_type'(eff_kind + 3'd1));
            if (after == KIND_NONE) begin
               // end of this sample's fields
               new_remain  = eff_remain - 32'd1;
               new_counter = eff_counter + 32'd1;
               next_kind   = (new_remain == 32'd0) ? KIND_NONE
                           : next_sample_kind(eff_flags, KIND_DURATION);
            end else begin
               next_kind = after;
            end
         end
      endcase

      q_pop = q_not_empty && (!ov_ff || out_ready);
      load  = q_pop && !eff_done;

      field_in   = field_ff;
      flags_in   = flags_ff;
      remain_in  = remain_ff;
      counter_in = counter_ff;
      done_in    = done_ff;
      if (load) begin
         flags_in   = eff_flags;
         remain_in  = new_remain;
         counter_in = new_counter;
         done_in    = (next_kind == KIND_NONE);
         field_in   = (next_kind == KIND_NONE) ? KIND_COUNT : next_kind;
      end

      ov_in    = load ? 1'b1 : (out_ready ? 1'b0 : ov_ff);
      ok_in    = load ? eff_kind : ok_ff;
      oval_in  = load ? q_entry.word : oval_ff;
      oidx_in  = load ? ((eff_kind >= KIND_DURATION) ? eff_counter : 32'd0) : oidx_ff;
      olast_in = load ? (next_kind == KIND_NONE) : olast_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff   <= KIND_COUNT;
         flags_ff   <= '0;
         remain_ff  <= 32'd0;
         counter_ff <= 32'd0;
         done_ff    <= 1'b1;
         ov_ff      <= 1'b0;
      end else begin
         field_ff   <= field_in;
         flags_ff   <= flags_in;
         remain_ff  <= remain_in;
         counter_ff <= counter_in;
         done_ff    <= done_in;
         ov_ff      <= ov_in;
      end
      ok_ff    <= ok_in;
      oval_ff  <= oval_in;
      oidx_ff  <= oidx_in;
      olast_ff <= olast_in;
   end

   assign out_valid = ov_ff;
   assign out_kind  = ok_ff;
   assign out_value = oval_ff;
   assign out_index = oidx_ff;
   assign out_last  = olast_ff;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> done_ff && !ov_ff)
      else $error("sequencer not idle after reset");

   a_header_index: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && (ok_ff == KIND_COUNT || ok_ff == KIND_DATA_OFFSET ||
                 ok_ff == KIND_FIRST_FLAGS)) |-> (oidx_ff == 32'd0))
      else $error("header field carries a sample index");

   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      (q_pop && done_ff && !q_entry.first) |=> $stable(counter_ff) && $stable(done_ff))
      else $error("word after end of run changed sequencer state");

   a_active_field: assert property (@(posedge clock) disable iff (reset)
      !done_ff |-> (field_ff != KIND_NONE))
      else $error("active run holds no field");

endmodule

/* sv/track_run_box_parser_top.sv */
// ----------------------------------------------------------------------------
// track_run_box_parser_top
// Track run box body parser, one byte per transfer in, one field per transfer out.
// ----------------------------------------------------------------------------
// Input stream (req_): one body byte per transfer, with the box flags in tdata
// and a start marker in tuser on the first byte of a body. Output stream (rsp_):
// one transfer per completed 32-bit field, with its kind in tuser, the value
// and sample index in tdata and tlast on the final field of the run.
// Throughput: one byte per cycle while req_tready is high; one field per four
// bytes on average, and fields held in the queue after a stall leave on
// back-to-back cycles. A field passes through the word queue and then the
// output register after its fourth byte transfer.
// Bytes after the run completes, or before any start, are consumed and
// dropped. A start mid-run abandons the partial word and restarts.
// Reset clears the byte position, the two-entry queue and the output
// register; the parser then waits for a start. When the receiver stalls the
// queue fills and req_tready drops once both entries are taken.
// ----------------------------------------------------------------------------
module track_run_box_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [7:0] data_byte, [31:8] box_flags
   input  logic        req_tuser,   // [0] box_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] field_value, [63:32] sample_number
   output logic [2:0]  rsp_tuser,   // [2:0] field_kind
   output logic        rsp_tlast    // run_last
);
   import trbp_pkg::*;

   logic           q_full, q_not_empty, q_push, q_pop, byte_accept;
   word_entry_type push_entry, pop_entry;
   kind_type       out_kind;
   logic [31:0]    out_value, out_index;

   assign req_tready  = !q_full;
   assign byte_accept = req_tvalid && req_tready;

   trbp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_tdata[7:0]),
      .box_start   (req_tuser),
      .box_flags   (req_tdata[31:8]),
      .push        (q_push),
      .push_entry  (push_entry)
   );

   trbp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .pop_entry  (pop_entry)
   );

   trbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_entry     (pop_entry),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (out_kind),
      .out_value   (out_value),
      .out_index   (out_index),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {out_index, out_value};
   assign rsp_tuser = out_kind;

endmodule

/* tb/track_run_box_parser_top_test.sv */
// ----------------------------------------------------------------------------
// track_run_box_parser_top_test
// Self-checking bench for the track run box parser: byte stream in, fields out.
// ----------------------------------------------------------------------------
// Box bodies are built word by word from random box flags and sample counts
// and sent one byte per transfer. A scoreboard tracks the parser state per
// accepted byte and queues the field each fourth byte completes; every
// output transfer is checked against the oldest queued field. Runs are mostly
// well formed, with abandoned runs, restarts mid-word and stray bytes mixed
// in. Both sides stall in random bursts, except near the end of the test.
// ----------------------------------------------------------------------------
import trbp_pkg::*;

class trun_fields;

   typedef struct {
      kind_type    kind;
      logic [31:0] value;
      logic [31:0] sample;
      logic        last;
   } field_rec;

   field_rec    pending[$];
   int          errors;

   logic [5:0]  held;
   logic [1:0]  pos;
   logic [23:0] acc;
   kind_type    cur;
   logic [31:0] remaining;
   logic [31:0] sample_idx;
   logic        idle;

   function new();
      errors     = 0;
      held       = '0;
      pos        = '0;
      acc        = '0;
      cur        = KIND_COUNT;
      remaining  = '0;
      sample_idx = '0;
      idle       = 1'b1;
   endfunction

   // first per-sample kind at or after 'from' whose flag is held
   function kind_type sample_kind_from(int from);
      for (int k = from; k <= int'(KIND_COMP_OFFSET); k++) begin
         if (held[k-1]) return kind_type'(k[2:0]);
      end
      return KIND_NONE;
   endfunction

   function kind_type sample_part();
      if (remaining == 32'd0) return KIND_NONE;
      return sample_kind_from(int'(KIND_DURATION));
   endfunction

   function void take_byte(logic [7:0] data, logic start, logic [23:0] flags);
      logic [31:0] word;
      kind_type    next;
      field_rec    got;
      if (start) begin
         held       = {flags[BOX_FLAG_SAMPLE_LO +: 4], flags[BOX_FLAG_FIRST_FLAGS],
                       flags[BOX_FLAG_DATA_OFFSET]};
         pos        = '0;
         acc        = '0;
         cur        = KIND_COUNT;
         remaining  = '0;
         sample_idx = '0;
         idle       = 1'b0;
      end
      if (idle) return;
      if (pos != 2'd3) begin
         acc = {acc[15:0], data};
         pos = pos + 2'd1;
         return;
      end
      word      = {acc, data};
      pos       = '0;
      acc       = '0;
      got.kind  = cur;
      got.value = word;
      got.sample = (cur >= KIND_DURATION) ? sample_idx : 32'd0;
      case (cur)
         KIND_COUNT: begin
            remaining = word;
            if (held[FLAG_DATA_OFFSET])
               next = KIND_DATA_OFFSET;
            else if (held[FLAG_FIRST_FLAGS])
               next = KIND_FIRST_FLAGS;
            else
               next = sample_part();
         end
         KIND_DATA_OFFSET: next = held[FLAG_FIRST_FLAGS] ? KIND_FIRST_FLAGS : sample_part();
         KIND_FIRST_FLAGS: next = sample_part();
         default: begin
            next = sample_kind_from(int'(cur) + 1);
            // last field of this sample: move on to the next one
            if (next == KIND_NONE) begin
               remaining  = remaining - 32'd1;
               sample_idx = sample_idx + 32'd1;
               next       = sample_part();
            end
         end
      endcase
      if (next == KIND_NONE) begin
         idle = 1'b1;
         cur  = KIND_COUNT;
      end else begin
         cur = next;
      end
      got.last = idle;
      pending.push_back(got);
   endfunction

   function void check_field(logic [2:0] kind, logic [31:0] value, logic [31:0] sample,
                             logic last);
      field_rec want;
      if (pending.size() == 0) begin
         $error("unexpected field transfer: kind %0d value %h", kind, value);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (kind != want.kind) begin
         $error("field_kind: expected %0d, got %0d", want.kind, kind);
         errors++;
      end
      if (value != want.value) begin
         $error("field_value: expected %h, got %h", want.value, value);
         errors++;
      end
      if (sample != want.sample) begin
         $error("sample_number: expected %0d, got %0d", want.sample, sample);
         errors++;
      end
      if (last != want.last) begin
         $error("run_last: expected %0d, got %0d", want.last, last);
         errors++;
      end
   endfunction

endclass

module track_run_box_parser_top_test;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [7:0] data_byte, [31:8] box_flags
   logic        req_tuser;    // [0] box_start
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;    // [31:0] field_value, [63:32] sample_number
   logic [2:0]  rsp_tuser;    // [2:0] field_kind
   logic        rsp_tlast;

   trun_fields  fields;
   logic [7:0]  body_bytes[$];
   int          sent_bytes;
   bit          quiet;
   bit          calm;
   bit          rx_calm;

   track_run_box_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         fields.check_field(rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tlast);
   end

   // receiver: random stall bursts, with calm stretches
   initial begin
      rsp_tready <= 1'b0;
      rx_calm = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 63) == 0) rx_calm = $urandom_range(0, 1);
         if (!quiet && !rx_calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic void push_word(logic [31:0] w);
      body_bytes.push_back(w[31:24]);
      body_bytes.push_back(w[23:16]);
      body_bytes.push_back(w[15:8]);
      body_bytes.push_back(w[7:0]);
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic start,
                            input logic [23:0] flags);
      if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {flags, data};
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fields.take_byte(data, start, flags);
      sent_bytes++;
   endtask

   // start marker and flags ride on the first byte only
   task automatic send_body(input logic [23:0] flags);
      for (int i = 0; i < body_bytes.size(); i++)
         send_byte(body_bytes[i], i == 0, (i == 0) ? flags : 24'($urandom));
      body_bytes.delete();
   endtask

   task automatic send_random_run();
      logic [23:0] flags;
      logic [31:0] count;
      int          per;
      int          samples;
      int          keep;
      bit          broken;
      flags = 24'($urandom);
      if ($urandom_range(0, 1)) flags &= 24'h000F05;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: count = $urandom_range(0, 3);
         6, 7:             count = $urandom_range(4, 8);
         8:                count = $urandom;
         default:          count = 32'hFFFF_FFFF;
      endcase
      per = flags[8] + flags[9] + flags[10] + flags[11];
      push_word(count);
      if (flags[BOX_FLAG_DATA_OFFSET]) push_word(rand_word());
      if (flags[BOX_FLAG_FIRST_FLAGS]) push_word(rand_word());
      if (per != 0) begin
         samples = (count > 32'd8) ? 8 : int'(count);
         for (int s = 0; s < samples; s++) begin
            for (int b = 0; b < 4; b++)
               if (flags[BOX_FLAG_SAMPLE_LO + b]) push_word(rand_word());
         end
      end
      // huge counts with sample fields never finish; cut them, and some others
      broken = (count > 32'd8 && per != 0) || ($urandom_range(0, 6) == 0);
      if (broken) begin
         keep = $urandom_range(1, body_bytes.size());
         while (body_bytes.size() > keep) void'(body_bytes.pop_back());
      end
      send_body(flags);
   endtask

   initial begin
      fields     = new();
      sent_bytes = 0;
      quiet      = 1'b0;
      calm       = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // stray bytes before any start
      send_byte(8'h5A, 1'b0, 24'hFFFFFF);
      send_byte(8'hA5, 1'b0, 24'h000F05);
      // no flags: count alone ends the run, whatever its value
      push_word(32'hFFFF_FFFF);
      send_body(24'h000000);
      // zero samples with both header options, negative data offset
      push_word(32'h0000_0000);
      push_word(32'h8000_0000);
      push_word(32'h0000_0000);
      send_body(24'h000F05);
      // restart mid-word
      body_bytes.push_back(8'hFF);
      body_bytes.push_back(8'h00);
      send_body(24'hFFFFFF);
      push_word(32'h0000_0001);
      push_word(32'hFF00_FF00);
      send_body(24'h000100);
      // byte after the run completes is dropped
      send_byte(8'hFF, 1'b0, 24'hFFFFFF);

      while (sent_bytes < 900) begin
         if (sent_bytes >= 800) quiet = 1'b1;
         calm = ($urandom_range(0, 4) == 0);
         send_random_run();
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, 24'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      while (fields.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fields.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
